// ===== design/pbe_pkg.sv =====
// ============================================================================
// pbe_pkg
// Shared constants, codes and controller/datapath link types for the
// PackBits encoder.
// ============================================================================
package pbe_pkg;

    localparam int MAX_PACKET = 128;
    localparam int BUF_DEPTH  = MAX_PACKET + 2;
    localparam int WORD_BYTES = 8;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int LEN_W      = $clog2(MAX_PACKET + 1);
    localparam int LANE_W     = $clog2(WORD_BYTES);
    localparam int VCNT_W     = 4;

    localparam logic [7:0] END_BYTE = 8'd128;
    localparam logic [8:0] RUN_BIAS = 9'd257;

    // what an input item does to the pending buffer
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_RUN_CLOSE = 3'd1;
    localparam logic [2:0] ACT_TRIPLE    = 3'd2;
    localparam logic [2:0] ACT_FULL      = 3'd3;
    localparam logic [2:0] ACT_FLUSH     = 3'd4;

    // kind of the first packet an item emits
    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_RUN  = 2'd1;
    localparam logic [1:0] PK_LIT  = 2'd2;

    // code byte source select
    localparam logic [2:0] SRC_RUN_HDR = 3'd0;
    localparam logic [2:0] SRC_RUN_VAL = 3'd1;
    localparam logic [2:0] SRC_LIT_HDR = 3'd2;
    localparam logic [2:0] SRC_MEM     = 3'd3;
    localparam logic [2:0] SRC_END     = 3'd4;

    typedef struct packed {
        logic       idle;       // ready for a new item
        logic       byte_vld;   // a code byte is offered to the packer
        logic [2:0] src;        // code byte source
        logic       fin;        // offered byte is the last one of the item
        logic       rd_en;      // read buffer at rd_idx, advance rd_idx
        logic       load_rem;   // load literal byte counter from packet length
        logic       dec_rem;    // one literal byte taken
        logic       load_tail;  // switch to the tail literal of a flush
        logic       fill_we;    // rewrite buffer head after a forced packet
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] act;
        logic [1:0] pk;
        logic       tail;       // flush has a one-byte tail literal
        logic       take;       // packer took the offered byte
        logic       rem_last;   // last literal byte is on offer
        logic       fill_last;
    } sts_t;

endpackage

// ===== design/pbe_in_if.sv =====
// ============================================================================
// pbe_in_if
// Input channel of the PackBits encoder: opcode and raw data byte.
// ============================================================================
interface pbe_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// ===== design/pbe_out_if.sv =====
// ============================================================================
// pbe_out_if
// Output channel of the PackBits encoder: up to eight code bytes per beat.
// ============================================================================
interface pbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
    logic [3:0] valid_count;
    logic       last_word;

    modport source (
        output valid, output byte_0, output byte_1, output byte_2, output byte_3,
        output byte_4, output byte_5, output byte_6, output byte_7,
        output valid_count, output last_word, input ready
    );
    modport sink (
        input valid, input byte_0, input byte_1, input byte_2, input byte_3,
        input byte_4, input byte_5, input byte_6, input byte_7,
        input valid_count, input last_word, output ready
    );
endinterface

// ===== design/pbe_dpath.sv =====
// ============================================================================
// pbe_dpath
// Datapath: pending buffer memory, mode and shadow registers, item
// classification, code byte select and the eight-byte word packer.
// ============================================================================
module pbe_dpath
    import pbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pbe_in_if.sink     raw,
    pbe_out_if.source  code,
    input  cmd_t       cmd,
    output sts_t       sts
);

    // pending buffer
    logic [7:0]        mem [0:BUF_DEPTH-1];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] rd_idx_reg;

    // control state
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              tail_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic              fill_idx_reg;
    logic [LANE_W-1:0] asm_cnt_reg;
    logic              ov_reg;

    // shadows of buffer entries: first, last and second to last
    logic [7:0]        head_reg;
    logic [7:0]        last_reg;
    logic [7:0]        prev_reg;

    // job of the current item
    logic [LEN_W-1:0]  job_len_reg;
    logic [7:0]        job_val_reg;
    logic [LEN_W-1:0]  tail_len_reg;
    logic [7:0]        fill_a_reg;
    logic [7:0]        fill_b_reg;

    // packer
    logic [7:0]        asm_reg [0:WORD_BYTES-1];
    logic [7:0]        word_reg [0:WORD_BYTES-1];
    logic [7:0]        word_next [0:WORD_BYTES-1];
    logic [VCNT_W-1:0] vcnt_reg;
    logic              lastw_reg;

    logic              accept;
    logic [7:0]        b;
    logic [CNT_W-1:0]  c1;
    logic              eq_last;
    logic              eq_prev;
    logic              eq_head;
    logic [2:0]        act;
    logic [1:0]        pk;
    logic [LEN_W-1:0]  flush_len;
    logic [LEN_W-1:0]  job_len_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        code_byte;
    logic              completes;
    logic              out_free;
    logic              take;

    assign accept  = cmd.idle && raw.valid;
    assign b       = raw.data_byte;
    assign c1      = cnt_reg + CNT_W'(1);
    assign eq_last = (b == last_reg);
    assign eq_prev = (b == prev_reg);
    assign eq_head = (b == head_reg);

    always_comb
    begin
        if (raw.opcode)
            act = ACT_FLUSH;
        else if (c1 > CNT_W'(2) && run_reg && !eq_head && c1 <= CNT_W'(MAX_PACKET))
            act = ACT_RUN_CLOSE;
        else if (c1 > CNT_W'(2) && !run_reg && eq_last && eq_prev)
            act = ACT_TRIPLE;
        else if (c1 == CNT_W'(BUF_DEPTH))
            act = ACT_FULL;
        else
            act = ACT_NONE;
    end

    assign flush_len = (cnt_reg > CNT_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : LEN_W'(cnt_reg);

    always_comb
    begin
        pk           = PK_NONE;
        job_len_next = LEN_W'(MAX_PACKET);
        unique case (act)
            ACT_RUN_CLOSE:
            begin
                pk           = PK_RUN;
                job_len_next = LEN_W'(cnt_reg);
            end
            ACT_TRIPLE:
            begin
                pk           = PK_LIT;
                job_len_next = LEN_W'(cnt_reg - CNT_W'(2));
            end
            ACT_FULL:
            begin
                pk           = run_reg ? PK_RUN : PK_LIT;
                job_len_next = LEN_W'(MAX_PACKET);
            end
            ACT_FLUSH:
            begin
                job_len_next = flush_len;
                if (cnt_reg > CNT_W'(MAX_PACKET))
                    pk = run_reg ? PK_RUN : PK_LIT;
                else if (cnt_reg >= CNT_W'(2) && run_reg)
                    pk = PK_RUN;
                else if (cnt_reg >= CNT_W'(1))
                    pk = PK_LIT;
                else
                    pk = PK_NONE;
            end
            default:
            begin
                pk           = PK_NONE;
                job_len_next = LEN_W'(MAX_PACKET);
            end
        endcase
    end

    // single write port: new byte on accept, head rewrite after a forced packet
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = b;
        if (accept && !raw.opcode)
        begin
            wr_en   = 1'b1;
            wr_addr = (act == ACT_RUN_CLOSE) ? '0 : ADDR_W'(cnt_reg);
            wr_data = b;
        end
        else if (cmd.fill_we)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(fill_idx_reg);
            wr_data = fill_idx_reg ? fill_b_reg : fill_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_idx_reg];
    end

    // code byte select
    always_comb
    begin
        case (cmd.src)
            SRC_RUN_HDR: code_byte = 8'(RUN_BIAS - 9'(job_len_reg));
            SRC_RUN_VAL: code_byte = job_val_reg;
            SRC_LIT_HDR: code_byte = 8'(job_len_reg - LEN_W'(1));
            SRC_MEM:     code_byte = rdata_reg;
            SRC_END:     code_byte = END_BYTE;
            default:     code_byte = '0;
        endcase
    end

    // packer: a word goes out on the eighth byte or on the item's last byte
    assign completes = cmd.fin || (asm_cnt_reg == LANE_W'(WORD_BYTES - 1));
    assign out_free  = !ov_reg || code.ready;
    assign take      = cmd.byte_vld && (!completes || out_free);

    always_comb
    begin
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            if (j < int'(asm_cnt_reg))
                word_next[j] = asm_reg[j];
            else if (j == int'(asm_cnt_reg))
                word_next[j] = code_byte;
            else
                word_next[j] = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            run_reg      <= 1'b0;
            tail_reg     <= 1'b0;
            rem_reg      <= '0;
            rd_idx_reg   <= '0;
            fill_idx_reg <= 1'b0;
            asm_cnt_reg  <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rd_idx_reg   <= '0;
                fill_idx_reg <= 1'b0;
                tail_reg     <= raw.opcode && (cnt_reg > CNT_W'(MAX_PACKET));
                case (act)
                    ACT_RUN_CLOSE:
                        cnt_reg <= CNT_W'(1);
                    ACT_TRIPLE:
                    begin
                        cnt_reg <= CNT_W'(3);
                        run_reg <= 1'b1;
                    end
                    ACT_FULL:
                    begin
                        cnt_reg <= CNT_W'(2);
                        run_reg <= eq_last;
                    end
                    ACT_FLUSH:
                    begin
                        cnt_reg <= '0;
                        run_reg <= 1'b0;
                    end
                    default:
                    begin
                        cnt_reg <= c1;
                        if (cnt_reg == CNT_W'(1))
                            run_reg <= eq_last;
                    end
                endcase
            end
            else if (cmd.load_tail)
                rd_idx_reg <= ADDR_W'(MAX_PACKET);
            else if (cmd.rd_en)
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);

            if (cmd.load_rem)
                rem_reg <= job_len_reg;
            else if (cmd.dec_rem)
                rem_reg <= rem_reg - LEN_W'(1);

            if (cmd.fill_we)
                fill_idx_reg <= ~fill_idx_reg;

            if (take)
            begin
                if (completes)
                begin
                    asm_cnt_reg <= '0;
                    ov_reg      <= 1'b1;
                end
                else
                begin
                    asm_cnt_reg <= asm_cnt_reg + LANE_W'(1);
                    if (code.ready)
                        ov_reg <= 1'b0;
                end
            end
            else if (code.ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_len_reg  <= job_len_next;
            job_val_reg  <= head_reg;
            tail_len_reg <= LEN_W'(cnt_reg - CNT_W'(MAX_PACKET));
            case (act)
                ACT_RUN_CLOSE:
                begin
                    head_reg <= b;
                    last_reg <= b;
                end
                ACT_TRIPLE:
                begin
                    head_reg <= b;
                    last_reg <= b;
                    prev_reg <= b;
                end
                ACT_FULL:
                begin
                    head_reg   <= last_reg;
                    prev_reg   <= last_reg;
                    last_reg   <= b;
                    fill_a_reg <= last_reg;
                    fill_b_reg <= b;
                end
                ACT_FLUSH:
                begin
                    head_reg <= head_reg;
                end
                default:
                begin
                    if (cnt_reg == '0)
                        head_reg <= b;
                    prev_reg <= last_reg;
                    last_reg <= b;
                end
            endcase
        end
        else if (cmd.load_tail)
            job_len_reg <= tail_len_reg;

        if (take)
        begin
            if (completes)
            begin
                for (int j = 0; j < WORD_BYTES; j++)
                    word_reg[j] <= word_next[j];
                vcnt_reg  <= VCNT_W'(asm_cnt_reg) + VCNT_W'(1);
                lastw_reg <= cmd.fin;
            end
            else
                asm_reg[asm_cnt_reg] <= code_byte;
        end
    end

    assign raw.ready        = cmd.idle;
    assign code.valid       = ov_reg;
    assign code.byte_0      = word_reg[0];
    assign code.byte_1      = word_reg[1];
    assign code.byte_2      = word_reg[2];
    assign code.byte_3      = word_reg[3];
    assign code.byte_4      = word_reg[4];
    assign code.byte_5      = word_reg[5];
    assign code.byte_6      = word_reg[6];
    assign code.byte_7      = word_reg[7];
    assign code.valid_count = vcnt_reg;
    assign code.last_word   = lastw_reg;

    assign sts.in_valid  = raw.valid;
    assign sts.act       = act;
    assign sts.pk        = pk;
    assign sts.tail      = tail_reg;
    assign sts.take      = take;
    assign sts.rem_last  = (rem_reg == LEN_W'(1));
    assign sts.fill_last = fill_idx_reg;

endmodule

// ===== design/pbe_ctrl.sv =====
// ============================================================================
// pbe_ctrl
// Controller: takes an item, then steps through the packets it causes,
// one code byte per beat toward the packer.
// ============================================================================
module pbe_ctrl
    import pbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RUN_HDR = 3'd1;
    localparam logic [2:0] S_RUN_VAL = 3'd2;
    localparam logic [2:0] S_LIT_HDR = 3'd3;
    localparam logic [2:0] S_LIT_DAT = 3'd4;
    localparam logic [2:0] S_FILL    = 3'd5;
    localparam logic [2:0] S_END     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] act_reg;
    logic [2:0] act_next;
    logic       tail_done_reg;
    logic       tail_done_next;
    logic [2:0] post_state;
    logic       post_tail;
    logic       is_flush;

    assign is_flush = (act_reg == ACT_FLUSH);

    // where to go once a packet's last byte is taken
    always_comb
    begin
        post_tail  = 1'b0;
        post_state = S_IDLE;
        if (is_flush)
        begin
            if (sts.tail && !tail_done_reg)
            begin
                post_state = S_LIT_HDR;
                post_tail  = 1'b1;
            end
            else
                post_state = S_END;
        end
        else if (act_reg == ACT_FULL)
            post_state = S_FILL;
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        act_next       = act_reg;
        tail_done_next = tail_done_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                begin
                    act_next       = sts.act;
                    tail_done_next = 1'b0;
                    if (sts.pk == PK_RUN)
                        state_next = S_RUN_HDR;
                    else if (sts.pk == PK_LIT)
                        state_next = S_LIT_HDR;
                    else if (sts.act == ACT_FLUSH)
                        state_next = S_END;
                    else
                        state_next = S_IDLE;
                end
            end
            S_RUN_HDR:
            begin
                cmd.byte_vld = 1'b1;
                cmd.src      = SRC_RUN_HDR;
                if (sts.take)
                    state_next = S_RUN_VAL;
            end
            S_RUN_VAL:
            begin
                cmd.byte_vld = 1'b1;
                cmd.src      = SRC_RUN_VAL;
                cmd.fin      = !is_flush;
                if (sts.take)
                begin
                    state_next     = post_state;
                    cmd.load_tail  = post_tail;
                    tail_done_next = tail_done_reg || post_tail;
                end
            end
            S_LIT_HDR:
            begin
                cmd.byte_vld = 1'b1;
                cmd.src      = SRC_LIT_HDR;
                if (sts.take)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.load_rem = 1'b1;
                    state_next   = S_LIT_DAT;
                end
            end
            S_LIT_DAT:
            begin
                cmd.byte_vld = 1'b1;
                cmd.src      = SRC_MEM;
                cmd.fin      = sts.rem_last && !is_flush;
                if (sts.take)
                begin
                    cmd.dec_rem = 1'b1;
                    if (!sts.rem_last)
                        cmd.rd_en = 1'b1;
                    else
                    begin
                        state_next     = post_state;
                        cmd.load_tail  = post_tail;
                        tail_done_next = tail_done_reg || post_tail;
                    end
                end
            end
            S_FILL:
            begin
                cmd.fill_we = 1'b1;
                if (sts.fill_last)
                    state_next = S_IDLE;
            end
            S_END:
            begin
                cmd.byte_vld = 1'b1;
                cmd.src      = SRC_END;
                cmd.fin      = 1'b1;
                if (sts.take)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_NONE;
            tail_done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            tail_done_reg <= tail_done_next;
        end
    end

endmodule

// ===== design/packbits_encoder_top.sv =====
// ============================================================================
// packbits_encoder_top
// PackBits run-length encoder, raw bytes in, packed code words out.
// ============================================================================
// Usage:
//   raw  : one beat per input item, opcode 0 = data byte, 1 = end of stream.
//   code : up to eight code bytes per beat, valid_count of them used from
//          byte_0 upward, last_word set on the final beat an item causes.
// A data byte that closes no packet leaves the controller idle; such
// bytes go in back to back. An item that closes a packet holds raw.ready
// low while the packet is sent, one code byte per cycle unless the packer
// stalls: header and value for a run, header and n bytes for an n-byte
// literal, whose bytes come from the single read port of the 130-entry
// pending buffer. A forced 128-byte packet on a full buffer is followed by
// a rewrite of the two buffer head entries. An end item sends at most 132
// bytes. A code word is presented the cycle after its last byte is packed.
// Reset empties the buffer count, selects literal mode and drops any word
// on the output; buffer memory is not cleared. When code.ready is low the
// pending word holds and byte generation stops at the next completed word.
// ============================================================================
module packbits_encoder_top
    import pbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pbe_in_if.sink    raw,
    pbe_out_if.source code
);

    cmd_t cmd;
    sts_t sts;

    pbe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pbe_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw),
        .code  (code),
        .cmd   (cmd),
        .sts   (sts)
    );

    // a byte the packer refused is offered again
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.byte_vld && !sts.take |=> cmd.byte_vld)
        else $error("code byte dropped while packer stalled");

    // no byte generation or buffer rewrite while taking input
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        raw.ready |-> !cmd.byte_vld && !cmd.fill_we)
        else $error("controller busy while input ready");

    // the item's last byte closes a word marked last
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.byte_vld && cmd.fin && sts.take |=> code.valid && code.last_word)
        else $error("final code byte did not produce a last word");

endmodule

// ===== tb/packbits_encoder_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// packbits_encoder_top_tb
// Self-checking bench for the PackBits encoder. A directed table covers the
// corner cases: empty end, one-byte flush, run close, triple start and short
// runs. Random byte streams follow, with short mixes, noise and full-length
// runs and literals that force packets and overlong flushes. Every code word
// is checked against typed-in values or an in-bench encoder model. Both
// channels idle at random; the receiver holds off once for a long stretch.
// ============================================================================
module packbits_encoder_top_tb
    import pbe_pkg::*;
();

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int RAND_ITEMS   = 356;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [63:0] lanes;   // byte_0 in [7:0]
        logic [3:0]  cnt;
        logic        last;
    } code_word_t;

    typedef struct packed {
        logic       op;
        logic [7:0] dat;
        logic       fixed;     // expectation typed in below
        logic       one_word;  // fixed: one word, else none
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
        logic [3:0] ecnt;
    } dir_row_t;

    typedef enum int {SEQ_MIX, SEQ_RAND, SEQ_NOISE, SEQ_LONG_LIT, SEQ_LONG_RUN} seq_kind_t;

    localparam int DIR_N = 24;
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{OP_END,  8'h00, 1'b1, 1'b1, 8'h80, 8'h00, 8'h00, 4'd1},  // empty stream end
        '{OP_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_END,  8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h80, 4'd3},  // one-byte literal
        '{OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h00, 1'b1, 1'b1, 8'hFE, 8'hFF, 8'h00, 4'd2},  // run of 3 closes
        '{OP_END,  8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h80, 4'd3},  // one byte, run flag set
        '{OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h02, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h03, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h03, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h03, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h03, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h7F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_END,  8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{OP_END,  8'h00, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h80, 4'd3}   // run of 2 flushed
    };

    logic clk;
    logic rst_n;

    pbe_in_if  raw_ch ();
    pbe_out_if code_ch ();

    packbits_encoder_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .code  (code_ch)
    );

    // encoder model state
    logic [7:0]  pend [BUF_DEPTH];
    int unsigned pend_cnt;
    bit          run_mode;
    logic [7:0]  code_bytes [$];
    code_word_t  words_due [$];

    int  mism_cnt;
    int  items_sent;
    int  src_burst;
    int  cycle_cnt;
    bit  hold_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_code(logic [7:0] cb);
        code_bytes.insert(code_bytes.size(), cb);
    endfunction

    function automatic void add_word(code_word_t cw);
        words_due.insert(words_due.size(), cw);
    endfunction

    function automatic void put_run(int unsigned n, logic [7:0] v);
        add_code(8'(int'(RUN_BIAS) - n));
        add_code(v);
    endfunction

    function automatic void put_lit(int unsigned start, int unsigned n);
        if (n == 0)
            return;
        add_code(8'(n - 1));
        for (int unsigned i = 0; i < n; i++)
            add_code(pend[start + i]);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int unsigned c;
        logic [7:0]  prev;
        pend[pend_cnt] = b;
        pend_cnt++;
        c = pend_cnt;
        if (c == 2)
        begin
            run_mode = (pend[0] == pend[1]);
            return;
        end
        if (c > 2)
        begin
            // a differing byte ends a run, unless the run is already overlong
            if (run_mode && b != pend[0] && c <= MAX_PACKET)
            begin
                put_run(c - 1, pend[0]);
                pend[0]  = b;
                pend_cnt = 1;
                return;
            end
            if (!run_mode && b == pend[c - 2] && b == pend[c - 3])
            begin
                put_lit(0, c - 3);
                pend[0]  = b;
                pend[1]  = b;
                pend[2]  = b;
                pend_cnt = 3;
                run_mode = 1'b1;
                return;
            end
        end
        if (c == BUF_DEPTH)
        begin
            prev = pend[c - 2];
            if (run_mode)
                put_run(MAX_PACKET, pend[0]);
            else
                put_lit(0, MAX_PACKET);
            pend[0]  = prev;
            pend[1]  = b;
            pend_cnt = 2;
            run_mode = (prev == b);
        end
    endfunction

    function automatic void flush_stream();
        int unsigned c;
        c = pend_cnt;
        if (c > MAX_PACKET)
        begin
            if (run_mode)
                put_run(MAX_PACKET, pend[0]);
            else
                put_lit(0, MAX_PACKET);
            put_lit(MAX_PACKET, c - MAX_PACKET);
        end
        else if (c >= 2 && run_mode)
            put_run(c, pend[0]);
        else if (c >= 1)
            put_lit(0, c);
        add_code(END_BYTE);
        pend_cnt = 0;
        run_mode = 1'b0;
    endfunction

    function automatic void encode_item(logic op, logic [7:0] d);
        code_bytes.delete();
        if (op == OP_END)
            flush_stream();
        else
            take_byte(d);
    endfunction

    function automatic void queue_words();
        int n;
        code_word_t w;
        n = code_bytes.size();
        for (int k = 0; k < n; k += WORD_BYTES)
        begin
            w = '0;
            for (int j = 0; j < WORD_BYTES && k + j < n; j++)
                w.lanes[8*j +: 8] = code_bytes[k + j];
            w.cnt  = 4'((n - k < WORD_BYTES) ? n - k : WORD_BYTES);
            w.last = (k + WORD_BYTES >= n);
            add_word(w);
        end
    endfunction

    // returns right after the accepting edge
    task automatic send_item(logic op, logic [7:0] d);
        int gap;
        if (src_burst > 0)
        begin
            gap = 0;
            src_burst--;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 15) == 0)
                src_burst = $urandom_range(10, 60);
        end
        if (gap > 0)
        begin
            raw_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_ch.valid     <= 1'b1;
        raw_ch.opcode    <= op;
        raw_ch.data_byte <= d;
        do
            @(posedge clk);
        while (raw_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic feed(logic op, logic [7:0] d);
        send_item(op, d);
        encode_item(op, d);
        queue_words();
    endtask

    task automatic log_bad(string what, code_word_t want, code_word_t got);
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS)
            $display("%0t %s: expected lanes=%h cnt=%0d last=%0d, got lanes=%h cnt=%0d last=%0d",
                     $realtime, what, want.lanes, want.cnt, want.last,
                     got.lanes, got.cnt, got.last);
    endtask

    // output beat checker
    always @(posedge clk)
    begin
        code_word_t got;
        code_word_t want;
        if (rst_n === 1'b1 && code_ch.valid === 1'b1 && code_ch.ready === 1'b1)
        begin
            got.lanes = {code_ch.byte_7, code_ch.byte_6, code_ch.byte_5, code_ch.byte_4,
                         code_ch.byte_3, code_ch.byte_2, code_ch.byte_1, code_ch.byte_0};
            got.cnt   = code_ch.valid_count;
            got.last  = code_ch.last_word;
            if (words_due.size() == 0)
                log_bad("unexpected word", '0, got);
            else
            begin
                want = words_due.pop_front();
                if (got.lanes !== want.lanes || got.cnt !== want.cnt
                    || got.last !== want.last)
                    log_bad("word mismatch", want, got);
            end
        end
    end

    // receiver: random stalls, no-stall stretches, one long hold-off
    initial
    begin : recv_ctl
        int stall_left;
        int run_left;
        bit hold_done;
        bit rdy;
        stall_left = 0;
        run_left   = 0;
        hold_done  = 1'b0;
        code_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                run_left   = 0;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    run_left = $urandom_range(20, 80);
                else
                begin
                    stall_left = idle_len();
                    run_left   = $urandom_range(1, 6);
                end
            end
            if (stall_left > 0)
            begin
                rdy = 1'b0;
                stall_left--;
            end
            else
            begin
                rdy = 1'b1;
                run_left--;
            end
            code_ch.ready <= rdy;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : stim
        seq_kind_t  kind;
        int         seq_no;
        int         r;
        int         len;
        int         rep;
        logic [7:0] v;
        logic [7:0] pa;
        logic [7:0] pb;
        code_word_t w;
        dir_row_t   row;

        pend_cnt   = 0;
        run_mode   = 1'b0;
        mism_cnt   = 0;
        items_sent = 0;
        src_burst  = 0;
        cycle_cnt  = 0;
        hold_req   = 1'b0;
        raw_ch.valid     <= 1'b0;
        raw_ch.opcode    <= OP_DATA;
        raw_ch.data_byte <= 8'h00;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);

        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_TAB[i];
            send_item(row.op, row.dat);
            encode_item(row.op, row.dat);
            if (!row.fixed)
                queue_words();
            else if (row.one_word)
            begin
                w       = '0;
                w.lanes = {40'h0, row.e2, row.e1, row.e0};
                w.cnt   = row.ecnt;
                w.last  = 1'b1;
                add_word(w);
            end
        end

        hold_req <= 1'b1;
        seq_no = 0;
        while (items_sent < DIR_N + RAND_ITEMS)
        begin
            // start with one long literal and one long run around the packet length
            if (seq_no == 0)
                kind = SEQ_LONG_LIT;
            else if (seq_no == 1)
                kind = SEQ_LONG_RUN;
            else
            begin
                r = $urandom_range(0, 99);
                kind = (r < 45) ? SEQ_MIX : (r < 80) ? SEQ_RAND : (r < 92) ? SEQ_NOISE :
                       (r < 96) ? SEQ_LONG_LIT : SEQ_LONG_RUN;
            end
            seq_no++;
            case (kind)
                SEQ_MIX:
                begin
                    // two-value alphabet with short repeats: runs and triples
                    len = $urandom_range(1, 24);
                    pa  = 8'($urandom);
                    pb  = $urandom_range(0, 1) ? 8'(pa + 1) : 8'($urandom);
                    while (len > 0)
                    begin
                        v   = $urandom_range(0, 1) ? pa : pb;
                        rep = $urandom_range(1, 5);
                        if (rep > len)
                            rep = len;
                        repeat (rep) feed(OP_DATA, v);
                        len -= rep;
                    end
                end
                SEQ_RAND:
                    repeat ($urandom_range(1, 12)) feed(OP_DATA, 8'($urandom));
                SEQ_NOISE:
                    repeat ($urandom_range(1, 6))
                        feed(($urandom_range(0, 3) == 0) ? OP_END : OP_DATA, 8'($urandom));
                SEQ_LONG_LIT:
                begin
                    // distinct neighbors; last byte may repeat to flip the mode on a full buffer
                    len = $urandom_range(MAX_PACKET - 2, BUF_DEPTH + 1);
                    v   = 8'($urandom);
                    for (int i = 0; i < len; i++)
                    begin
                        if (i == len - 1 && $urandom_range(0, 1))
                            feed(OP_DATA, 8'(v - 1));
                        else
                        begin
                            feed(OP_DATA, v);
                            v = 8'(v + 1);
                        end
                    end
                end
                SEQ_LONG_RUN:
                begin
                    len = $urandom_range(MAX_PACKET - 2, BUF_DEPTH + 1);
                    v   = 8'($urandom);
                    repeat (len) feed(OP_DATA, v);
                end
                default: ;
            endcase
            if (kind != SEQ_NOISE && $urandom_range(0, 4) != 0)
                feed(OP_END, 8'($urandom));
        end

        raw_ch.valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mism_cnt == 0 && words_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
